FILE: rtl/core/ghs_pkg.sv
package ghs_pkg;

    localparam int IN_LEVEL_BITS  = 8;
    localparam int OUT_LEVEL_BITS = 8;
    localparam int MEAN_BITS      = 16;
    localparam int SD_BITS        = 15;

    localparam logic [MEAN_BITS-1:0] MEAN_MAX = '1;
    localparam logic [SD_BITS-1:0]   SD_MAX   = '1;

    typedef struct packed {
        logic [IN_LEVEL_BITS-1:0] pixel;
        logic                     last;
    } in_t;

    typedef struct packed {
        logic [OUT_LEVEL_BITS-1:0] min_level;
        logic [OUT_LEVEL_BITS-1:0] max_level;
        logic [OUT_LEVEL_BITS-1:0] level_span;
        logic [MEAN_BITS-1:0]      mean_level;
        logic [SD_BITS-1:0]        std_dev;
        logic                      empty_res;
    } out_t;

endpackage

FILE: rtl/core/gray_histogram_statistics_top.sv
// Throughput: one pixel request per cycle while full is low;
// full rises only when two closed images wait.
// Per image the back end (L = min(LEVEL_BITS,8)) runs three shift-add multiplies,
// two restoring divides and one bit-pair square root.
// An image with no counted pixel skips the arithmetic and goes from idle through done to the output.
// Reset (rst_n low, asynchronous) clears the accumulators, queues and the zero-skip setting.
module gray_histogram_statistics_top #(
    parameter int PIXEL_COUNT_BITS = 20,
    parameter int LEVEL_BITS       = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  ghs_pkg::in_t  in_data,
    output logic          empty,
    input  logic          pop,
    output ghs_pkg::out_t out_data,
    input  logic          cfg_wen,
    input  logic          cfg_wdata
);
    import ghs_pkg::*;

    localparam int LW  = (LEVEL_BITS > IN_LEVEL_BITS) ? IN_LEVEL_BITS : LEVEL_BITS;
    localparam int CW  = PIXEL_COUNT_BITS + 1;
    localparam int SNW = CW + (CW + LW) + (CW + 2 * LW) + 2 * LW;

    logic           accept;
    logic           snap_push;
    logic [SNW-1:0] snap_in;
    logic [SNW-1:0] snap_out;
    logic           snap_full;
    logic           snap_empty;
    logic           snap_pop;

    assign full   = snap_full;
    assign accept = push && !snap_full;

    ghs_front #(
        .CW (CW),
        .LW (LW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .in_data   (in_data),
        .snap_push (snap_push),
        .snap_data (snap_in)
    );

    ghs_queue #(
        .WIDTH (SNW),
        .DEPTH (2)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (snap_push),
        .din   (snap_in),
        .full  (snap_full),
        .pop   (snap_pop),
        .dout  (snap_out),
        .empty (snap_empty)
    );

    ghs_back #(
        .CW (CW),
        .LW (LW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_empty (snap_empty),
        .snap_data  (snap_out),
        .snap_pop   (snap_pop),
        .empty      (empty),
        .pop        (pop),
        .out_data   (out_data)
    );

endmodule

FILE: rtl/core/ghs_front.sv
module ghs_front #(
    parameter int CW = 21,
    parameter int LW = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic                                 cfg_wdata,
    input  logic                                 accept,
    input  ghs_pkg::in_t                         in_data,
    output logic                                 snap_push,
    output logic [CW+(CW+LW)+(CW+2*LW)+2*LW-1:0] snap_data
);
    import ghs_pkg::*;

    localparam int SW  = CW + LW;
    localparam int QSW = CW + 2 * LW;

    logic            iz_reg;
    logic [CW-1:0]   cnt_reg;
    logic [SW-1:0]   sum_reg;
    logic [QSW-1:0]  sq_reg;
    logic [LW-1:0]   min_reg;
    logic [LW-1:0]   max_reg;

    logic [LW-1:0]   px;
    logic [2*LW-1:0] px_sq;
    logic            counted;
    logic [CW-1:0]   cnt_next;
    logic [SW-1:0]   sum_next;
    logic [QSW-1:0]  sq_next;
    logic [LW-1:0]   min_next;
    logic [LW-1:0]   max_next;

    assign px      = in_data.pixel[LW-1:0];
    assign px_sq   = (2*LW)'(px) * (2*LW)'(px);
    assign counted = !(iz_reg && (px == '0)) && !cnt_reg[CW-1];

    always_comb
    begin
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        sq_next  = sq_reg;
        min_next = min_reg;
        max_next = max_reg;
        if (counted)
        begin
            cnt_next = cnt_reg + CW'(1);
            sum_next = sum_reg + SW'(px);
            sq_next  = sq_reg + QSW'(px_sq);
            if (px < min_reg)
            begin
                min_next = px;
            end
            if (px > max_reg)
            begin
                max_next = px;
            end
        end
    end

    assign snap_push = accept && in_data.last;
    assign snap_data = {cnt_next, sum_next, sq_next, min_next, max_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iz_reg  <= 1'b0;
            cnt_reg <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
            min_reg <= '1;
            max_reg <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                iz_reg <= cfg_wdata;
            end
            if (accept)
            begin
                if (in_data.last)
                begin
                    cnt_reg <= '0;
                    sum_reg <= '0;
                    sq_reg  <= '0;
                    min_reg <= '1;
                    max_reg <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_next;
                    sum_reg <= sum_next;
                    sq_reg  <= sq_next;
                    min_reg <= min_next;
                    max_reg <= max_next;
                end
            end
        end
    end

endmodule

FILE: rtl/core/ghs_queue.sv
module ghs_queue #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == NW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

endmodule

FILE: rtl/core/ghs_back.sv
module ghs_back #(
    parameter int CW = 21,
    parameter int LW = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 snap_empty,
    input  logic [CW+(CW+LW)+(CW+2*LW)+2*LW-1:0] snap_data,
    output logic                                 snap_pop,
    output logic                                 empty,
    input  logic                                 pop,
    output ghs_pkg::out_t                        out_data
);
    import ghs_pkg::*;

    localparam int SW   = CW + LW;
    localparam int QSW  = CW + 2 * LW;
    localparam int PW   = CW + QSW;
    localparam int QW   = 2 * LW + 16;
    localparam int DSW  = PW + QW;
    localparam int MAXS = (SW > QW) ? SW : QW;
    localparam int CTW  = $clog2(MAXS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_SQRT,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        MUL_NS2,
        MUL_SS,
        MUL_NN
    } mul_sel_t;

    typedef enum logic {
        DIV_MEAN,
        DIV_VAR
    } div_sel_t;

    logic [CW-1:0]  snap_n;
    logic [SW-1:0]  snap_s;
    logic [QSW-1:0] snap_s2;
    logic [LW-1:0]  snap_mn;
    logic [LW-1:0]  snap_mx;

    state_t           state_reg;
    mul_sel_t         mul_sel_reg;
    div_sel_t         div_sel_reg;
    logic [CTW-1:0]   step_reg;
    logic [CW-1:0]    n_reg;
    logic [SW-1:0]    s_reg;
    logic [LW-1:0]    mn_reg;
    logic [LW-1:0]    mx_reg;
    logic [PW-1:0]    acc_reg;
    logic [PW-1:0]    mcand_reg;
    logic [SW-1:0]    mplier_reg;
    logic [PW-1:0]    diff_reg;
    logic [2*CW-1:0]  dvsr_reg;
    logic [DSW-1:0]   rem_reg;
    logic [DSW-1:0]   ds_reg;
    logic [QW-1:0]    quo_reg;
    logic [QW-1:0]    v_reg;
    logic [QW-1:0]    root_reg;
    logic [QW-1:0]    bit_reg;
    logic [MEAN_BITS-1:0] mean_reg;
    logic [SD_BITS-1:0]   sd_reg;
    logic             none_reg;
    logic             out_valid_reg;
    out_t             out_reg;

    logic [PW-1:0]    mul_sum;
    logic             div_ge;
    logic [DSW-1:0]   div_rem;
    logic [QW-1:0]    quo_next;
    logic [QW:0]      sq_trial;
    logic             sq_ge;
    logic [QW-1:0]    root_next;
    logic [QW-1:0]    v_next;
    logic             last_step;
    logic             out_free;
    logic             out_load;
    logic [MEAN_BITS-1:0] mean_sat;
    logic [SD_BITS-1:0]   sd_sat;

    assign {snap_n, snap_s, snap_s2, snap_mn, snap_mx} = snap_data;

    assign mul_sum   = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign div_ge    = (rem_reg >= ds_reg);
    assign div_rem   = div_ge ? (rem_reg - ds_reg) : rem_reg;
    assign quo_next  = {quo_reg[QW-2:0], div_ge};
    assign sq_trial  = {1'b0, root_reg} + {1'b0, bit_reg};
    assign sq_ge     = ({1'b0, v_reg} >= sq_trial);
    assign root_next = sq_ge ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);
    assign v_next    = sq_ge ? (v_reg - sq_trial[QW-1:0]) : v_reg;
    assign last_step = (step_reg == CTW'(1));
    assign out_free  = !out_valid_reg || pop;
    assign out_load  = (state_reg == S_DONE) && out_free;
    assign mean_sat  = (quo_next > QW'(MEAN_MAX)) ? MEAN_MAX : quo_next[MEAN_BITS-1:0];
    assign sd_sat    = (root_next > QW'(SD_MAX)) ? SD_MAX : root_next[SD_BITS-1:0];

    assign snap_pop  = (state_reg == S_IDLE) && !snap_empty;
    assign empty     = !out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mul_sel_reg   <= MUL_NS2;
            div_sel_reg   <= DIV_MEAN;
            step_reg      <= '0;
            n_reg         <= '0;
            s_reg         <= '0;
            mn_reg        <= '0;
            mx_reg        <= '0;
            acc_reg       <= '0;
            mcand_reg     <= '0;
            mplier_reg    <= '0;
            diff_reg      <= '0;
            dvsr_reg      <= '0;
            rem_reg       <= '0;
            ds_reg        <= '0;
            quo_reg       <= '0;
            v_reg         <= '0;
            root_reg      <= '0;
            bit_reg       <= '0;
            mean_reg      <= '0;
            sd_reg        <= '0;
            none_reg      <= 1'b0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!snap_empty)
                    begin
                        n_reg  <= snap_n;
                        s_reg  <= snap_s;
                        mn_reg <= snap_mn;
                        mx_reg <= snap_mx;
                        if (snap_n == '0)
                        begin
                            none_reg  <= 1'b1;
                            mean_reg  <= '0;
                            sd_reg    <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            none_reg    <= 1'b0;
                            acc_reg     <= '0;
                            mcand_reg   <= PW'(snap_s2);
                            mplier_reg  <= SW'(snap_n);
                            step_reg    <= CTW'(SW);
                            mul_sel_reg <= MUL_NS2;
                            state_reg   <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    if (last_step)
                    begin
                        acc_reg <= '0;
                        unique case (mul_sel_reg)
                            MUL_NS2:
                            begin
                                diff_reg    <= mul_sum;
                                mcand_reg   <= PW'(s_reg);
                                mplier_reg  <= s_reg;
                                step_reg    <= CTW'(SW);
                                mul_sel_reg <= MUL_SS;
                            end
                            MUL_SS:
                            begin
                                diff_reg    <= diff_reg - mul_sum;
                                mcand_reg   <= PW'(n_reg);
                                mplier_reg  <= SW'(n_reg);
                                step_reg    <= CTW'(SW);
                                mul_sel_reg <= MUL_NN;
                            end
                            MUL_NN:
                            begin
                                dvsr_reg    <= mul_sum[2*CW-1:0];
                                rem_reg     <= DSW'(s_reg) << 8;
                                ds_reg      <= DSW'(n_reg) << (QW - 1);
                                quo_reg     <= '0;
                                step_reg    <= CTW'(QW);
                                div_sel_reg <= DIV_MEAN;
                                state_reg   <= S_DIV;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                    else
                    begin
                        acc_reg    <= mul_sum;
                        mcand_reg  <= mcand_reg << 1;
                        mplier_reg <= mplier_reg >> 1;
                        step_reg   <= step_reg - CTW'(1);
                    end
                end
                S_DIV:
                begin
                    if (last_step)
                    begin
                        unique case (div_sel_reg)
                            DIV_MEAN:
                            begin
                                mean_reg    <= mean_sat;
                                rem_reg     <= DSW'(diff_reg) << 16;
                                ds_reg      <= DSW'(dvsr_reg) << (QW - 1);
                                quo_reg     <= '0;
                                step_reg    <= CTW'(QW);
                                div_sel_reg <= DIV_VAR;
                            end
                            DIV_VAR:
                            begin
                                v_reg     <= quo_next;
                                root_reg  <= '0;
                                bit_reg   <= QW'(1) << (QW - 2);
                                step_reg  <= CTW'(QW / 2);
                                state_reg <= S_SQRT;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                    else
                    begin
                        rem_reg  <= div_rem;
                        ds_reg   <= ds_reg >> 1;
                        quo_reg  <= quo_next;
                        step_reg <= step_reg - CTW'(1);
                    end
                end
                S_SQRT:
                begin
                    v_reg    <= v_next;
                    root_reg <= root_next;
                    bit_reg  <= bit_reg >> 2;
                    step_reg <= step_reg - CTW'(1);
                    if (last_step)
                    begin
                        sd_reg    <= sd_sat;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_reg.min_level  <= none_reg ? '0 : OUT_LEVEL_BITS'(mn_reg);
                        out_reg.max_level  <= none_reg ? '0 : OUT_LEVEL_BITS'(mx_reg);
                        out_reg.level_span <= none_reg ? '0 : OUT_LEVEL_BITS'(mx_reg - mn_reg);
                        out_reg.mean_level <= mean_reg;
                        out_reg.std_dev    <= sd_reg;
                        out_reg.empty_res  <= none_reg;
                        state_reg          <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/ghs_checker.sv
module ghs_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          empty,
    input logic          pop,
    input ghs_pkg::out_t out_data
);
    import ghs_pkg::*;

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_data.empty_res) |->
            (out_data.min_level == '0) && (out_data.max_level == '0) &&
            (out_data.level_span == '0) && (out_data.mean_level == '0) &&
            (out_data.std_dev == '0))
        else $error("empty image result carries nonzero fields");

    a_span: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_data.empty_res) |->
            (out_data.min_level <= out_data.max_level) &&
            (out_data.level_span == (out_data.max_level - out_data.min_level)))
        else $error("span does not match min and max");

    a_mean_sd_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_data.empty_res) |->
            (out_data.mean_level >= {out_data.min_level, 8'h00}) &&
            (out_data.mean_level <= {out_data.max_level, 8'h00}) &&
            ({1'b0, out_data.std_dev} <= {1'b0, out_data.level_span, 7'h00}))
        else $error("mean or deviation outside the level range");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_data)))
        else $error("waiting result request changed before pop");

endmodule

bind gray_histogram_statistics_top ghs_checker u_chk (.*);
